FILE: rtl/pl0_lexical_scanner_top_macros.svh
// Assertion macros used by the scanner top level.
`ifndef PL0_LEXICAL_SCANNER_TOP_MACROS_SVH
`define PL0_LEXICAL_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define PL0_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define PL0_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pl0_pkg.sv
// Types, constants and keyword table of the PL/0 lexical scanner.
`timescale 1ns / 1ps

package pl0_pkg;

    localparam int IDENT_MAX_CHARS = 10;
    localparam int NUMBER_WIDTH    = 31;

    localparam int IDX_AW     = $clog2(IDENT_MAX_CHARS);
    localparam int CNT_W      = $clog2(IDENT_MAX_CHARS + 1);
    localparam int OUT_CHARS  = 10;
    localparam int HALF_CHARS = 5;
    localparam int VIEW_CHARS = (IDENT_MAX_CHARS > OUT_CHARS) ? IDENT_MAX_CHARS : OUT_CHARS;
    localparam int NUM_OUT_W  = 31;
    localparam int ACC_EXT_W  = NUMBER_WIDTH + 4;

    localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = '1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] CASE_SHIFT = 8'd32;

    typedef enum logic [5:0] {
        TOK_BEGIN, TOK_CALL, TOK_CONST, TOK_DO, TOK_ELSE, TOK_END, TOK_FOR, TOK_IF,
        TOK_ODD, TOK_PROCEDURE, TOK_PROGRAM, TOK_THEN, TOK_TO, TOK_VAR, TOK_WHILE,
        TOK_NONE, TOK_IDENT, TOK_NUMBER, TOK_PLUS, TOK_MINUS, TOK_TIMES, TOK_SLASH,
        TOK_EQU, TOK_NEQ, TOK_LSS, TOK_LEQ, TOK_GTR, TOK_GEQ, TOK_LPARENT,
        TOK_RPARENT, TOK_LBRACK, TOK_RBRACK, TOK_PERIOD, TOK_COMMA, TOK_SEMICOLON,
        TOK_ASSIGN, TOK_PERCENT
    } t_token;

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_LT, MODE_GT,
        MODE_COLON, MODE_SLASH, MODE_COMMENT, MODE_STAR
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        t_token                token_kind;
        logic [NUM_OUT_W-1:0]  number_value;
        logic [39:0]           ident_first;
        logic [39:0]           ident_second;
        logic [3:0]            ident_length;
        logic                  ident_truncated;
        logic                  last_in_run;
    } t_out_item;

    // Keywords, first character in the top byte, zero padded to nine characters.
    localparam int KW_COUNT = 15;
    localparam int KW_CHARS = 9;
    typedef logic [KW_CHARS-1:0][7:0] t_kw_text;

    localparam t_kw_text KW_TEXT [KW_COUNT] = '{
        {"BEGIN", 32'h0}, {"CALL", 40'h0}, {"CONST", 32'h0}, {"DO", 56'h0},
        {"ELSE", 40'h0}, {"END", 48'h0}, {"FOR", 48'h0}, {"IF", 56'h0},
        {"ODD", 48'h0}, {"PROCEDURE"}, {"PROGRAM", 16'h0}, {"THEN", 40'h0},
        {"TO", 56'h0}, {"VAR", 48'h0}, {"WHILE", 32'h0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd4, 4'd5, 4'd2, 4'd4, 4'd3, 4'd3, 4'd2,
        4'd3, 4'd9, 4'd7, 4'd4, 4'd2, 4'd3, 4'd5
    };

endpackage

FILE: rtl/pl0_lexical_scanner_top.sv
// Top level of the PL/0 lexical scanner: character decode, token state and result queue.
`timescale 1ns / 1ps
`include "pl0_lexical_scanner_top_macros.svh"

// The scanner takes one source character per input transaction on i_in_data
// (i_in_valid / o_in_stall) and returns tokens as output transactions on
// o_out_data (o_out_valid / i_out_stall). A transaction completes at a rising
// edge where valid is high and stall is low. Setting end_of_input flushes any
// pending token and returns the scanner to idle; its char_code is ignored.
// Tokens caused by a character enter the result queue at the edge where the
// character is taken. Throughput is one character per cycle while the queue
// has room. A character can cause up to two tokens, and the output side moves
// at most one token per cycle, so a run of two-token characters is paced by
// the output port. Tokens wait in a four-entry queue; the input stalls whenever
// fewer than two entries are free, so a stalled receiver never loses tokens
// and the scanner keeps accepting characters while one result is waiting.
// Synchronous active-low reset empties the queue and puts the scanner in idle
// with cleared counters. The identifier character store is not reset; only
// characters written for the current identifier are ever read.
module pl0_lexical_scanner_top
    import pl0_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // Scanner state.
    t_mode                   r_mode, n_mode;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_ovf, n_ovf;
    logic [NUMBER_WIDTH-1:0] r_acc, n_acc;
    logic [7:0]              r_store [IDENT_MAX_CHARS];

    // Result queue.
    t_out_item               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0]      r_fcount;

    logic                    in_fire, out_fire;
    logic [7:0]              c;
    logic                    is_letter, is_digit, is_blank;
    logic [3:0]              digit;

    logic                    st_we;
    logic [IDX_AW-1:0]       st_addr;

    t_token                  start_kind, pend_kind, ident_kind;
    logic                    start_emit, pend_emit, do_start;
    t_mode                   start_mode;

    logic [VIEW_CHARS-1:0][7:0] view;
    logic [ACC_EXT_W-1:0]    acc_next;
    logic                    kw_hit;

    t_out_item               pend_item, start_item, first_item;
    logic [1:0]              push_n;

    assign o_in_stall  = r_fcount > FIFO_CW'(FIFO_DEPTH - 2);
    assign o_out_valid = r_fcount != '0;
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_fire    = o_out_valid && !i_out_stall;

    // Lower-case letters are folded before any decision is made.
    always_comb begin
        c = i_in_data.char_code;
        if (c inside {["a":"z"]}) begin
            c = c - CASE_SHIFT;
        end
        is_letter = c inside {["A":"Z"]};
        is_digit  = c inside {["0":"9"]};
        is_blank  = c inside {" ", 8'd9, 8'd10};
        digit     = 4'(c - ASCII_ZERO);
    end

    // What a character does when it opens a new token.
    always_comb begin
        start_kind = TOK_NONE;
        start_emit = 1'b0;
        start_mode = MODE_IDLE;
        if (is_letter) begin
            start_mode = MODE_IDENT;
        end else if (is_digit) begin
            start_mode = MODE_NUMBER;
        end else if (!is_blank) begin
            start_emit = 1'b1;
            case (c)
                "+":     start_kind = TOK_PLUS;
                "-":     start_kind = TOK_MINUS;
                "*":     start_kind = TOK_TIMES;
                "=":     start_kind = TOK_EQU;
                "(":     start_kind = TOK_LBRACK;
                ")":     start_kind = TOK_RBRACK;
                "[":     start_kind = TOK_LPARENT;
                "]":     start_kind = TOK_RPARENT;
                ",":     start_kind = TOK_COMMA;
                ";":     start_kind = TOK_SEMICOLON;
                ".":     start_kind = TOK_PERIOD;
                "<": begin
                    start_emit = 1'b0;
                    start_mode = MODE_LT;
                end
                ">": begin
                    start_emit = 1'b0;
                    start_mode = MODE_GT;
                end
                ":": begin
                    start_emit = 1'b0;
                    start_mode = MODE_COLON;
                end
                "/": begin
                    start_emit = 1'b0;
                    start_mode = MODE_SLASH;
                end
                default: start_kind = TOK_NONE;
            endcase
        end
    end

    // Kept identifier characters, zero beyond the current length.
    always_comb begin
        view = '0;
        for (int j = 0; j < IDENT_MAX_CHARS; j++) begin
            if (CNT_W'(j) < r_count) begin
                view[j] = r_store[j];
            end
        end
    end

    // Keyword lookup over all fifteen entries in parallel.
    always_comb begin
        logic hit;
        ident_kind = TOK_IDENT;
        kw_hit     = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = !r_ovf && (r_count == CNT_W'(KW_LEN[k]));
            for (int j = 0; j < KW_CHARS; j++) begin
                if ((4'(j) < KW_LEN[k]) && (view[j] != KW_TEXT[k][KW_CHARS-1-j])) begin
                    hit = 1'b0;
                end
            end
            if (hit && !kw_hit) begin
                kw_hit     = 1'b1;
                ident_kind = t_token'(k);
            end
        end
    end

    // acc * 10 + digit, four bits wider than the accumulator so the saturation test cannot wrap.
    assign acc_next = (ACC_EXT_W'(r_acc) << 3) + (ACC_EXT_W'(r_acc) << 1) + ACC_EXT_W'(digit);

    // Next state and the pending token closed by this transaction.
    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_acc     = r_acc;
        st_we     = 1'b0;
        st_addr   = r_count[IDX_AW-1:0];
        pend_emit = 1'b0;
        pend_kind = TOK_NONE;
        do_start  = 1'b0;
        if (in_fire) begin
            if (i_in_data.end_of_input) begin
                pend_emit = 1'b1;
                case (r_mode)
                    MODE_IDENT:  pend_kind = ident_kind;
                    MODE_NUMBER: pend_kind = TOK_NUMBER;
                    MODE_LT:     pend_kind = TOK_LSS;
                    MODE_GT:     pend_kind = TOK_GTR;
                    MODE_COLON:  pend_kind = TOK_NONE;
                    MODE_SLASH:  pend_kind = TOK_SLASH;
                    default:     pend_emit = 1'b0;
                endcase
                n_mode  = MODE_IDLE;
                n_count = '0;
                n_ovf   = 1'b0;
                n_acc   = '0;
            end else begin
                case (r_mode)
                    MODE_IDENT: begin
                        if (is_letter || is_digit) begin
                            if (r_count < CNT_W'(IDENT_MAX_CHARS)) begin
                                st_we   = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            pend_emit = 1'b1;
                            pend_kind = ident_kind;
                            do_start  = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_digit) begin
                            if (acc_next > ACC_EXT_W'(NUM_MAX)) begin
                                n_acc = NUM_MAX;
                            end else begin
                                n_acc = acc_next[NUMBER_WIDTH-1:0];
                            end
                        end else begin
                            pend_emit = 1'b1;
                            pend_kind = TOK_NUMBER;
                            do_start  = 1'b1;
                        end
                    end
                    MODE_LT: begin
                        pend_emit = 1'b1;
                        n_mode    = MODE_IDLE;
                        if (c == ">") begin
                            pend_kind = TOK_NEQ;
                        end else if (c == "=") begin
                            pend_kind = TOK_LEQ;
                        end else begin
                            pend_kind = TOK_LSS;
                            do_start  = 1'b1;
                        end
                    end
                    MODE_GT: begin
                        pend_emit = 1'b1;
                        n_mode    = MODE_IDLE;
                        if (c == "=") begin
                            pend_kind = TOK_GEQ;
                        end else begin
                            pend_kind = TOK_GTR;
                            do_start  = 1'b1;
                        end
                    end
                    MODE_COLON: begin
                        pend_emit = 1'b1;
                        n_mode    = MODE_IDLE;
                        if (c == "=") begin
                            pend_kind = TOK_ASSIGN;
                        end else begin
                            pend_kind = TOK_NONE;
                            do_start  = 1'b1;
                        end
                    end
                    MODE_SLASH: begin
                        if (c == "*") begin
                            n_mode = MODE_COMMENT;
                        end else begin
                            pend_emit = 1'b1;
                            pend_kind = TOK_SLASH;
                            do_start  = 1'b1;
                        end
                    end
                    MODE_COMMENT: begin
                        if (c == "*") begin
                            n_mode = MODE_STAR;
                        end
                    end
                    MODE_STAR: begin
                        if (c == "/") begin
                            n_mode = MODE_IDLE;
                        end else if (c != "*") begin
                            n_mode = MODE_COMMENT;
                        end
                    end
                    default: do_start = 1'b1;
                endcase
                if (do_start) begin
                    n_mode = start_mode;
                    if (is_letter) begin
                        st_we   = 1'b1;
                        st_addr = '0;
                        n_count = CNT_W'(1);
                        n_ovf   = 1'b0;
                    end else if (is_digit) begin
                        n_acc = NUMBER_WIDTH'(digit);
                    end
                end
            end
        end
    end

    // Result items for the pending token and for the opening character.
    always_comb begin
        pend_item            = '0;
        pend_item.token_kind = pend_kind;
        if (pend_kind == TOK_NUMBER) begin
            pend_item.number_value = NUM_OUT_W'(r_acc);
        end
        if (pend_kind == TOK_IDENT) begin
            for (int j = 0; j < HALF_CHARS; j++) begin
                pend_item.ident_first[39-8*j -: 8]  = view[j];
                pend_item.ident_second[39-8*j -: 8] = view[j+HALF_CHARS];
            end
            pend_item.ident_length    = (r_count > CNT_W'(15)) ? 4'd15 : 4'(r_count);
            pend_item.ident_truncated = r_ovf;
        end
        pend_item.last_in_run = !(do_start && start_emit);

        start_item             = '0;
        start_item.token_kind  = start_kind;
        start_item.last_in_run = 1'b1;

        first_item = pend_emit ? pend_item : start_item;
        push_n     = 2'(pend_emit) + 2'(do_start && start_emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_acc    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fcount <= '0;
        end else begin
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_acc    <= n_acc;
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(push_n);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(out_fire);
            r_fcount <= r_fcount + FIFO_CW'(push_n) - FIFO_CW'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_addr] <= c;
        end
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_item;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= start_item;
        end
    end

    `PL0_ASSERT_NOW(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_fcount <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
    `PL0_ASSERT_NOW(a_fifo_ptrs, i_clk, i_rst_n, 1'b1, (r_wr_ptr - r_rd_ptr) == r_fcount[FIFO_AW-1:0], "queue pointers disagree with fill count")
    `PL0_ASSERT_NOW(a_ident_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(IDENT_MAX_CHARS), "identifier length beyond store depth")
    `PL0_ASSERT_NEXT(a_eoi_idle, i_clk, i_rst_n, in_fire && i_in_data.end_of_input, r_mode == MODE_IDLE && r_count == '0 && r_acc == '0, "end of input did not return scanner to idle")

endmodule

FILE: bench/pl0_lexical_scanner_checker.sv
// Token predictor and result checker for the PL/0 lexical scanner bench.
`timescale 1ns / 1ps

module pl0_lexical_scanner_checker
    import pl0_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_tokens_due
);

    localparam longint     NUMBER_SAT  = 64'h7FFF_FFFF;
    localparam int         NAME_KEEP   = 10;
    localparam logic [7:0] TAB         = 8'h09;
    localparam logic [7:0] LF          = 8'h0A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    string keyword_text [15] = '{"BEGIN", "CALL", "CONST", "DO", "ELSE", "END", "FOR",
                                 "IF", "ODD", "PROCEDURE", "PROGRAM", "THEN", "TO",
                                 "VAR", "WHILE"};

    t_mode      mode = MODE_IDLE;
    logic [7:0] name_chars [NAME_KEEP];
    int         name_len = 0;
    logic       name_cut = 1'b0;
    longint     num_acc = 0;
    t_out_item  pending_tokens [$];
    t_out_item  step_tokens [2];
    int         step_count = 0;
    int         fails = 0;
    t_out_item  want;

    function automatic bit is_letter(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic add_name_char(logic [7:0] c);
        if (name_len < NAME_KEEP) begin
            name_chars[name_len] = c;
            name_len++;
        end else begin
            name_cut = 1'b1;
        end
    endtask

    task automatic emit_token(t_token kind);
        t_out_item tok;
        tok = '0;
        tok.token_kind = kind;
        if (kind == TOK_NUMBER)
            tok.number_value = num_acc[30:0];
        step_tokens[step_count] = tok;
        step_count++;
    endtask

    // A cut identifier is never a keyword, whatever its first characters spell.
    task automatic emit_name();
        t_out_item tok;
        t_token    kind;
        bit        same;
        kind = TOK_IDENT;
        if (!name_cut) begin
            for (int k = 0; k < 15; k++) begin
                same = (keyword_text[k].len() == name_len);
                for (int j = 0; j < name_len && same; j++)
                    if (keyword_text[k][j] != name_chars[j])
                        same = 1'b0;
                if (same && kind == TOK_IDENT)
                    kind = t_token'(k);
            end
        end
        tok = '0;
        tok.token_kind = kind;
        if (kind == TOK_IDENT) begin
            for (int j = 0; j < name_len; j++) begin
                if (j < 5)
                    tok.ident_first[8 * (4 - j) +: 8] = name_chars[j];
                else
                    tok.ident_second[8 * (9 - j) +: 8] = name_chars[j];
            end
            tok.ident_length    = name_len[3:0];
            tok.ident_truncated = name_cut;
        end
        step_tokens[step_count] = tok;
        step_count++;
    endtask

    task automatic start_char(logic [7:0] c);
        mode = MODE_IDLE;
        if (c == " " || c == TAB || c == LF) begin
            mode = MODE_IDLE;
        end else if (is_letter(c)) begin
            name_len = 0;
            name_cut = 1'b0;
            add_name_char(c);
            mode = MODE_IDENT;
        end else if (is_digit(c)) begin
            num_acc = c - "0";
            mode = MODE_NUMBER;
        end else begin
            case (c)
                "+": emit_token(TOK_PLUS);
                "-": emit_token(TOK_MINUS);
                "*": emit_token(TOK_TIMES);
                "=": emit_token(TOK_EQU);
                "(": emit_token(TOK_LBRACK);
                ")": emit_token(TOK_RBRACK);
                "[": emit_token(TOK_LPARENT);
                "]": emit_token(TOK_RPARENT);
                ",": emit_token(TOK_COMMA);
                ";": emit_token(TOK_SEMICOLON);
                ".": emit_token(TOK_PERIOD);
                "<": mode = MODE_LT;
                ">": mode = MODE_GT;
                ":": mode = MODE_COLON;
                "/": mode = MODE_SLASH;
                default: emit_token(TOK_NONE);
            endcase
        end
    endtask

    // Advances the scanner by one character and queues the tokens it completes.
    task automatic scan_item(t_in_item item);
        logic [7:0] c;
        longint     digit;
        step_count = 0;
        if (item.end_of_input) begin
            case (mode)
                MODE_IDENT:  emit_name();
                MODE_NUMBER: emit_token(TOK_NUMBER);
                MODE_LT:     emit_token(TOK_LSS);
                MODE_GT:     emit_token(TOK_GTR);
                MODE_COLON:  emit_token(TOK_NONE);
                MODE_SLASH:  emit_token(TOK_SLASH);
                default: ;
            endcase
            mode     = MODE_IDLE;
            name_len = 0;
            name_cut = 1'b0;
            num_acc  = 0;
        end else begin
            c = item.char_code;
            if (c >= "a" && c <= "z")
                c = c - CASE_OFFSET;
            case (mode)
                MODE_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        add_name_char(c);
                    end else begin
                        emit_name();
                        start_char(c);
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c)) begin
                        digit = c - "0";
                        if (num_acc > (NUMBER_SAT - digit) / 10)
                            num_acc = NUMBER_SAT;
                        else
                            num_acc = num_acc * 10 + digit;
                    end else begin
                        emit_token(TOK_NUMBER);
                        start_char(c);
                    end
                end
                MODE_LT: begin
                    if (c == ">") begin
                        mode = MODE_IDLE;
                        emit_token(TOK_NEQ);
                    end else if (c == "=") begin
                        mode = MODE_IDLE;
                        emit_token(TOK_LEQ);
                    end else begin
                        emit_token(TOK_LSS);
                        start_char(c);
                    end
                end
                MODE_GT: begin
                    if (c == "=") begin
                        mode = MODE_IDLE;
                        emit_token(TOK_GEQ);
                    end else begin
                        emit_token(TOK_GTR);
                        start_char(c);
                    end
                end
                MODE_COLON: begin
                    if (c == "=") begin
                        mode = MODE_IDLE;
                        emit_token(TOK_ASSIGN);
                    end else begin
                        emit_token(TOK_NONE);
                        start_char(c);
                    end
                end
                MODE_SLASH: begin
                    if (c == "*") begin
                        mode = MODE_COMMENT;
                    end else begin
                        emit_token(TOK_SLASH);
                        start_char(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == "*")
                        mode = MODE_STAR;
                end
                MODE_STAR: begin
                    if (c == "/")
                        mode = MODE_IDLE;
                    else if (c != "*")
                        mode = MODE_COMMENT;
                end
                default: start_char(c);
            endcase
        end
        if (step_count > 0)
            step_tokens[step_count - 1].last_in_run = 1'b1;
        for (int k = 0; k < step_count; k++)
            pending_tokens.push_back(step_tokens[k]);
    endtask

    task automatic check_field(string field, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, expected, actual);
        end
    endtask

    // Results are checked before the new character is predicted, so a token can
    // never be matched against an expectation made in the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode     = MODE_IDLE;
            name_len = 0;
            name_cut = 1'b0;
            num_acc  = 0;
            pending_tokens.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_tokens.size() == 0) begin
                    fails++;
                    $display("%0t: token with none expected, expected nothing, actual %h",
                             $time, i_out_data);
                end else begin
                    want = pending_tokens.pop_front();
                    check_field("token_kind", want.token_kind, i_out_data.token_kind);
                    check_field("number_value", want.number_value, i_out_data.number_value);
                    check_field("ident_first", want.ident_first, i_out_data.ident_first);
                    check_field("ident_second", want.ident_second, i_out_data.ident_second);
                    check_field("ident_length", want.ident_length, i_out_data.ident_length);
                    check_field("ident_truncated", want.ident_truncated,
                                i_out_data.ident_truncated);
                    check_field("last_in_run", want.last_in_run, i_out_data.last_in_run);
                end
            end
            if (i_in_valid && !i_in_stall)
                scan_item(i_in_data);
        end
        o_fail_count <= fails;
        o_tokens_due <= pending_tokens.size();
    end

endmodule

FILE: bench/pl0_lexical_scanner_top_tb.sv
// Top of the PL/0 lexical scanner bench: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

// The bench feeds source characters into the scanner one transaction at a
// time and lets a separate checker predict and compare every token. This
// module only makes stimulus, plays the token receiver and prints the verdict.
//
// Stimulus starts with a short directed stretch: minus, every two-character
// operator, the bracket codes, the lone colon, a comment, characters outside
// the language, a number running into a letter, and end of input both with an
// identifier pending and inside an open comment. After that, random program
// text is built from fragments: keywords and near misses, identifiers (some
// longer than ten characters), numbers (some large enough to saturate),
// operators, comments, whitespace, stray bytes and end-of-input marks.
// Fragments are often butted together without whitespace, so that one
// character ends one token and produces another in the same transaction.
module pl0_lexical_scanner_top_tb;
    import pl0_pkg::*;

    localparam int         GAP_MAX      = 12;
    localparam int         PHASE_ITEMS  = 300;
    localparam int         PHASES       = 4;
    localparam int         SETTLE_TICKS = 8;
    localparam int         TIMEOUT_NS   = 1_000_000;
    localparam logic [7:0] TAB          = 8'h09;
    localparam logic [7:0] LF           = 8'h0A;
    localparam logic [7:0] CR           = 8'h0D;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int tokens_due;
    int scan_items  = 0;
    bit sender_calm = 1'b0;
    bit recv_calm   = 1'b0;
    int stall_left  = 0;
    int stall_draw;

    string op_text [19] = '{"+", "-", "*", "/", "=", "<", ">", ":", "(", ")", "[", "]",
                            ",", ";", ".", "<>", "<=", ">=", ":="};

    pl0_lexical_scanner_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    pl0_lexical_scanner_checker token_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_tokens_due (tokens_due)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard limit on the run; a correct run finishes far inside it.
    initial begin
        #(TIMEOUT_NS);
        $display("pl0_lexical_scanner_top regression: fail");
        $finish;
    end

    // Token receiver. After each accepted token it draws a stall length and
    // holds stall high while that length counts down. Calm stretches draw no stall at
    // all, so the output also sees long runs at full rate.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left != 1);
        end else if (out_valid && !out_stall) begin
            stall_draw = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            stall_left <= stall_draw;
            out_stall  <= (stall_draw != 0);
        end
    end

    // Sends one character transaction. An idle gap drawn per transaction comes
    // first; with no gap, valid simply stays high into the next transaction.
    // The payload holds still until the transaction is taken.
    task automatic send_char(logic [7:0] ch, logic flush);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in_item'({ch, flush});
        do @(posedge clk); while (in_stall);
        if (flush || !(ch == " " || ch == TAB || ch == LF))
            scan_items++;
    endtask

    task automatic send_text(string text);
        for (int j = 0; j < text.len(); j++)
            send_char(text[j], 1'b0);
    endtask

    // Letters go out in either case, since the scanner folds them.
    task automatic send_word_char(logic [7:0] ch);
        if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
            ch = ch + CASE_OFFSET;
        send_char(ch, 1'b0);
    endtask

    function automatic logic [7:0] random_letter();
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Holds the sender off until every token owed so far has been received.
    task automatic wait_for_tokens();
        in_valid <= 1'b0;
        do @(posedge clk); while (tokens_due != 0);
    endtask

    // One random piece of program text, mostly well formed, sometimes broken.
    task automatic send_fragment();
        int         pick;
        int         kw;
        int         len;
        int         variant;
        logic [7:0] ch;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1, 2: begin
                // Keyword as written, one character short, or one too long.
                kw      = $urandom_range(0, KW_COUNT - 1);
                len     = KW_LEN[kw];
                variant = $urandom_range(0, 3);
                if (variant == 1)
                    len = len - 1;
                for (int j = 0; j < len; j++)
                    send_word_char(KW_TEXT[kw][KW_CHARS - 1 - j]);
                if (variant == 2)
                    send_word_char($urandom_range(0, 1) ? random_letter() : random_digit());
            end
            3, 4, 5: begin
                // Identifier; about one in five may run past the ten kept characters.
                len = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 14 : 6);
                send_word_char(random_letter());
                for (int j = 1; j < len; j++)
                    send_word_char($urandom_range(0, 2) ? random_letter() : random_digit());
            end
            6, 7, 8: begin
                // Numbers, including the saturation boundary and values past it.
                variant = $urandom_range(0, 9);
                if (variant == 0) begin
                    send_text("2147483647");
                end else if (variant == 1) begin
                    send_text("2147483648");
                end else begin
                    len = $urandom_range(1, (variant < 4) ? 12 : 4);
                    for (int j = 0; j < len; j++)
                        send_char(random_digit(), 1'b0);
                end
            end
            9, 10, 11, 12: send_text(op_text[$urandom_range(0, 18)]);
            13, 14: begin
                // Comment whose body is full of stars and slashes; rarely left open.
                send_text("/*");
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++) begin
                    case ($urandom_range(0, 4))
                        0: ch = "*";
                        1: ch = "/";
                        2: ch = random_letter();
                        3: ch = " ";
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    send_char(ch, 1'b0);
                end
                if ($urandom_range(0, 7) != 0)
                    send_text("*/");
            end
            15: begin
                case ($urandom_range(0, 2))
                    0: ch = " ";
                    1: ch = TAB;
                    default: ch = LF;
                endcase
                send_char(ch, 1'b0);
            end
            16, 17: send_char(8'($urandom_range(0, 255)), 1'b0);
            18: begin
                // Characters outside the language.
                case ($urandom_range(0, 3))
                    0: ch = "%";
                    1: ch = CR;
                    2: ch = 8'h00;
                    default: ch = 8'($urandom_range(128, 255));
                endcase
                send_char(ch, 1'b0);
            end
            default: send_char(8'($urandom_range(0, 255)), 1'b1);
        endcase
        // Half the time the next fragment follows directly, with no separator.
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 2))
                0: send_char(" ", 1'b0);
                1: send_char(TAB, 1'b0);
                default: send_char(LF, 1'b0);
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed stretch. Minus, a lone colon ended by an opening square
        // bracket, both bracket pairs, all two-character operators, a comment,
        // then an identifier ended by a NUL.
        send_text("-:[(])<><=>=:=/*x*/q");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        // A number running straight into a letter, then end of input with the
        // identifier pending and every character bit set.
        send_text("7z");
        send_char(8'hFF, 1'b1);
        // End of input inside an open comment drops it silently.
        send_text("/*");
        send_char(8'h00, 1'b1);
        wait_for_tokens();

        // Random program text in phases, draining all tokens between phases.
        scan_items = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            while (scan_items < (phase + 1) * PHASE_ITEMS)
                send_fragment();
            wait_for_tokens();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0)
            $display("pl0_lexical_scanner_top regression: pass");
        else
            $display("pl0_lexical_scanner_top regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pl0_pkg.sv
rtl/pl0_lexical_scanner_top.sv
bench/pl0_lexical_scanner_checker.sv
bench/pl0_lexical_scanner_top_tb.sv
